/* hw/rtl/hts_pkg.sv */
package hts_pkg;

    localparam int GRID_SIZE_DEFAULT = 128;
    localparam int ALT_SHIFT_DEFAULT = 3;

    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 8;
    localparam int RES_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam logic [7:0] KERB_RESET = 8'd32;
    localparam logic [8:0] FRAC_ONE = 9'h100;
    localparam logic [7:0] FRAC_MASK = 8'hff;
    localparam int HEIGHT_MAX = 32767;
    localparam int HEIGHT_MIN = -32768;
    localparam logic signed [15:0] NO_FLOOR_HEIGHT = -16'sd32767;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        CFG_NO_FLOOR   = 1'b0,
        CFG_KERB_DEPTH = 1'b1
    } cfg_index_t;

    typedef struct packed {
        op_t                operation;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_z;
        logic [6:0]         cell_col;
        logic [6:0]         cell_row;
        logic signed [7:0]  cell_alt;
        logic               cell_sink;
    } item_t;

    typedef struct packed {
        logic signed [15:0] height;
        logic               on_map;
    } result_t;

    typedef struct packed {
        op_t               operation;
        logic              on_grid;
        logic              wr_ok;
        logic [7:0]        x;
        logic [7:0]        z;
        logic [7:0]        xf;
        logic [7:0]        zf;
        logic signed [7:0] alt;
        logic              sink;
    } cmd_t;

endpackage

/* hw/rtl/hts_fifo.sv */
module hts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty,
    output logic [CNTW-1:0]  count
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign dout    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

/* hw/rtl/hts_front.sv */
module hts_front #(
    parameter int GRID_SIZE = hts_pkg::GRID_SIZE_DEFAULT
) (
    input  hts_pkg::item_t item,
    input  logic           push,
    output logic           full,
    input  logic           clr_busy,
    input  logic           cmd_full,
    output logic           cmd_push,
    output hts_pkg::cmd_t  cmd
);

    logic signed [7:0] mx, mz;
    logic              on_grid;

    assign mx = item.pos_x[15:8];
    assign mz = item.pos_z[15:8];

    assign on_grid = (mx >= 8'sd0) && (32'(mx) <= GRID_SIZE - 2)
                  && (mz >= 8'sd0) && (32'(mz) <= GRID_SIZE - 2);

    assign full     = cmd_full || clr_busy;
    assign cmd_push = push && !full;

    always_comb
    begin
        cmd.operation = item.operation;
        cmd.on_grid   = on_grid;
        cmd.wr_ok     = (32'(item.cell_col) < GRID_SIZE) && (32'(item.cell_row) < GRID_SIZE);
        cmd.xf        = item.pos_x[7:0] & hts_pkg::FRAC_MASK;
        cmd.zf        = item.pos_z[7:0] & hts_pkg::FRAC_MASK;
        cmd.alt       = item.cell_alt;
        cmd.sink      = item.cell_sink;
        case (item.operation)
            hts_pkg::OP_WRITE:
            begin
                cmd.x = {1'b0, item.cell_col};
                cmd.z = {1'b0, item.cell_row};
            end
            hts_pkg::OP_QUERY:
            begin
                cmd.x = mx;
                cmd.z = mz;
            end
            default:
            begin
                cmd.x = '0;
                cmd.z = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/hts_back.sv */
module hts_back #(
    parameter int GRID_SIZE = hts_pkg::GRID_SIZE_DEFAULT,
    parameter int ALT_SHIFT = hts_pkg::ALT_SHIFT_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hts_pkg::cmd_t                   cmd,
    input  logic                            cmd_empty,
    output logic                            cmd_pop,
    input  logic                            no_floor,
    input  logic [7:0]                      kerb_depth,
    input  logic [hts_pkg::RES_CNT_W-1:0]   res_count,
    output logic                            res_push,
    output hts_pkg::result_t                res,
    output logic                            clr_busy
);

    localparam int HALF       = (GRID_SIZE + 1) / 2;
    localparam int BANK_DEPTH = HALF * HALF;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int HW         = 8 + ALT_SHIFT;
    localparam int DW         = HW + 1;
    localparam int PW         = DW + 10;
    localparam int SW         = (PW - 6 > 18) ? PW - 6 : 18;
    localparam int OCCW       = hts_pkg::RES_CNT_W + 1;

    logic            clr_busy_reg, clr_busy_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic            go, credit_ok, addr_ok;
    logic [OCCW-1:0] occ;
    logic [8:0]      rd_data [4];

    logic                 v1_reg, v2_reg, v3_reg;
    hts_pkg::cmd_t        s1_cmd_reg;
    hts_pkg::op_t         s2_op_reg, s3_op_reg;
    logic                 s2_inside_reg, s3_inside_reg;
    logic                 s2_sink_reg, s3_sink_reg;
    logic signed [HW-1:0] s2_base_reg, s3_base_reg;
    logic signed [DW-1:0] s2_da_reg, s2_db_reg;
    logic [8:0]           s2_wa_reg, s2_wb_reg;
    logic signed [PW-1:0] s3_pa_reg, s3_pb_reg;

    logic signed [7:0]    h0r, h1r, h2r, h3r;
    logic                 sink0, x0, z0, lower, flat;
    logic signed [HW-1:0] h0s, h1s, h2s, h3s;
    logic signed [HW-1:0] base_next;
    logic signed [DW-1:0] da_next, db_next;
    logic [8:0]           wa_next, wb_next;
    logic signed [SW-1:0] term_a, term_b, kerb_term, sum;
    logic signed [15:0]   clamped;

    assign clr_busy = clr_busy_reg;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(BANK_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    assign occ       = OCCW'(res_count) + OCCW'(v1_reg) + OCCW'(v2_reg) + OCCW'(v3_reg);
    assign credit_ok = occ < OCCW'(hts_pkg::OUT_DEPTH);
    assign go        = !cmd_empty && !clr_busy_reg && credit_ok;
    assign cmd_pop   = go;
    assign addr_ok   = (cmd.operation == hts_pkg::OP_QUERY) ? cmd.on_grid : cmd.wr_ok;

    for (genvar gi = 0; gi < 4; gi++)
    begin : g_bank
        localparam logic PX = 1'((gi >> 1) & 1);
        localparam logic PZ = 1'(gi & 1);

        logic [8:0]    mem [BANK_DEPTH];
        logic [8:0]    xb, zb;
        logic [AW-1:0] addr, wa;
        logic [8:0]    wd;
        logic          we;

        assign xb   = (cmd.x[0] == PX) ? {1'b0, cmd.x} : {1'b0, cmd.x} + 9'd1;
        assign zb   = (cmd.z[0] == PZ) ? {1'b0, cmd.z} : {1'b0, cmd.z} + 9'd1;
        assign addr = addr_ok ? AW'(32'(xb[8:1]) * 32'(HALF) + 32'(zb[8:1])) : '0;
        assign we   = clr_busy_reg
                   || (go && (cmd.operation == hts_pkg::OP_WRITE) && cmd.wr_ok
                       && (cmd.x[0] == PX) && (cmd.z[0] == PZ));
        assign wa   = clr_busy_reg ? clr_addr_reg : addr;
        assign wd   = clr_busy_reg ? 9'd0 : {cmd.sink, cmd.alt};

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem[wa] <= wd;
            end
            rd_data[gi] <= mem[addr];
        end
    end

    assign x0    = s1_cmd_reg.x[0];
    assign z0    = s1_cmd_reg.z[0];
    assign h0r   = x0 ? (z0 ? rd_data[3][7:0] : rd_data[2][7:0])
                      : (z0 ? rd_data[1][7:0] : rd_data[0][7:0]);
    assign sink0 = x0 ? (z0 ? rd_data[3][8] : rd_data[2][8])
                      : (z0 ? rd_data[1][8] : rd_data[0][8]);
    assign h1r   = x0 ? (z0 ? rd_data[2][7:0] : rd_data[3][7:0])
                      : (z0 ? rd_data[0][7:0] : rd_data[1][7:0]);
    assign h2r   = x0 ? (z0 ? rd_data[1][7:0] : rd_data[0][7:0])
                      : (z0 ? rd_data[3][7:0] : rd_data[2][7:0]);
    assign h3r   = x0 ? (z0 ? rd_data[0][7:0] : rd_data[1][7:0])
                      : (z0 ? rd_data[2][7:0] : rd_data[3][7:0]);

    assign h0s   = HW'(h0r) <<< ALT_SHIFT;
    assign h1s   = HW'(h1r) <<< ALT_SHIFT;
    assign h2s   = HW'(h2r) <<< ALT_SHIFT;
    assign h3s   = HW'(h3r) <<< ALT_SHIFT;
    assign flat  = (h0r == h1r) && (h1r == h2r) && (h2r == h3r);
    assign lower = (9'(s1_cmd_reg.xf) + 9'(s1_cmd_reg.zf)) < hts_pkg::FRAC_ONE;

    always_comb
    begin
        if (flat)
        begin
            base_next = h0s;
            da_next   = '0;
            db_next   = '0;
            wa_next   = 9'(s1_cmd_reg.xf);
            wb_next   = 9'(s1_cmd_reg.zf);
        end
        else if (lower)
        begin
            base_next = h0s;
            da_next   = DW'(h2s) - DW'(h0s);
            db_next   = DW'(h1s) - DW'(h0s);
            wa_next   = 9'(s1_cmd_reg.xf);
            wb_next   = 9'(s1_cmd_reg.zf);
        end
        else
        begin
            base_next = h3s;
            da_next   = DW'(h1s) - DW'(h3s);
            db_next   = DW'(h2s) - DW'(h3s);
            wa_next   = hts_pkg::FRAC_ONE - 9'(s1_cmd_reg.xf);
            wb_next   = hts_pkg::FRAC_ONE - 9'(s1_cmd_reg.zf);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            v1_reg       <= go;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s1_cmd_reg <= cmd;
        end
        if (v1_reg)
        begin
            s2_op_reg     <= s1_cmd_reg.operation;
            s2_inside_reg <= s1_cmd_reg.on_grid;
            s2_sink_reg   <= sink0;
            s2_base_reg   <= base_next;
            s2_da_reg     <= da_next;
            s2_db_reg     <= db_next;
            s2_wa_reg     <= wa_next;
            s2_wb_reg     <= wb_next;
        end
        if (v2_reg)
        begin
            s3_op_reg     <= s2_op_reg;
            s3_inside_reg <= s2_inside_reg;
            s3_sink_reg   <= s2_sink_reg;
            s3_base_reg   <= s2_base_reg;
            s3_pa_reg     <= s2_da_reg * $signed({1'b0, s2_wa_reg});
            s3_pb_reg     <= s2_db_reg * $signed({1'b0, s2_wb_reg});
        end
    end

    // floor division by 256 on each weighted term
    assign term_a    = SW'(s3_pa_reg >>> 8);
    assign term_b    = SW'(s3_pb_reg >>> 8);
    assign kerb_term = s3_sink_reg ? $signed(SW'({1'b0, kerb_depth})) : $signed(SW'(0));
    assign sum       = SW'(s3_base_reg) + term_a + term_b - kerb_term;

    always_comb
    begin
        if (sum > hts_pkg::HEIGHT_MAX)
        begin
            clamped = 16'(hts_pkg::HEIGHT_MAX);
        end
        else if (sum < hts_pkg::HEIGHT_MIN)
        begin
            clamped = 16'(hts_pkg::HEIGHT_MIN);
        end
        else
        begin
            clamped = sum[15:0];
        end
    end

    assign res_push = v3_reg;

    always_comb
    begin
        res.height = '0;
        res.on_map = 1'b0;
        case (s3_op_reg)
            hts_pkg::OP_WRITE:
            begin
                res.height = '0;
                res.on_map = 1'b0;
            end
            hts_pkg::OP_QUERY:
            begin
                res.on_map = s3_inside_reg;
                if (no_floor)
                begin
                    res.height = hts_pkg::NO_FLOOR_HEIGHT;
                end
                else if (s3_inside_reg)
                begin
                    res.height = clamped;
                end
            end
            default:
            begin
                res.height = '0;
                res.on_map = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/heightfield_triangle_sampler.sv */
// channel  | direction | handshake             | payload
// item     | in        | push / full           | hts_pkg::item_t
// result   | out       | empty / pop           | hts_pkg::result_t
// config   | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle while full is low; set by the four corner banks, one read per bank
// a taken item passes the command queue, s1 (bank read), s2, s3 and the result queue
// after reset full stays high while the four corner banks, (GRID_SIZE+1)/2 squared
// words each (4096 at 128), are swept to zero
// a stalled result side backs up the result queue, then the command queue, then full
module heightfield_triangle_sampler #(
    parameter int GRID_SIZE = hts_pkg::GRID_SIZE_DEFAULT,
    parameter int ALT_SHIFT = hts_pkg::ALT_SHIFT_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  hts_pkg::item_t        item,
    output logic                  empty,
    input  logic                  pop,
    output hts_pkg::result_t      result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  hts_pkg::cfg_index_t   cfg_index,
    input  logic [7:0]            cfg_data
);

    logic                          no_floor_reg, no_floor_next;
    logic [7:0]                    kerb_reg, kerb_next;
    logic                          clr_busy;
    logic                          cmd_full, cmd_push, cmd_empty, cmd_pop;
    hts_pkg::cmd_t                 cmd_in, cmd_out;
    logic                          res_push;
    hts_pkg::result_t              res_in;
    logic [hts_pkg::RES_CNT_W-1:0] res_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        no_floor_next = no_floor_reg;
        kerb_next     = kerb_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hts_pkg::CFG_NO_FLOOR:   no_floor_next = cfg_data[0];
                hts_pkg::CFG_KERB_DEPTH: kerb_next     = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_floor_reg <= 1'b0;
            kerb_reg     <= hts_pkg::KERB_RESET;
        end
        else
        begin
            no_floor_reg <= no_floor_next;
            kerb_reg     <= kerb_next;
        end
    end

    hts_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .item     (item),
        .push     (push),
        .full     (full),
        .clr_busy (clr_busy),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    hts_fifo #(
        .WIDTH ($bits(hts_pkg::cmd_t)),
        .DEPTH (hts_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_out),
        .empty (cmd_empty),
        .count ()
    );

    hts_back #(
        .GRID_SIZE (GRID_SIZE),
        .ALT_SHIFT (ALT_SHIFT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_out),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .no_floor   (no_floor_reg),
        .kerb_depth (kerb_reg),
        .res_count  (res_count),
        .res_push   (res_push),
        .res        (res_in),
        .clr_busy   (clr_busy)
    );

    hts_fifo #(
        .WIDTH ($bits(hts_pkg::result_t)),
        .DEPTH (hts_pkg::OUT_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (),
        .pop   (pop),
        .dout  (result),
        .empty (empty),
        .count (res_count)
    );

endmodule
